### design/vvr_pkg.sv
// Shared types, widths and constants for the Voigt vector rotation unit.
`default_nettype none
package vvr_pkg;

	localparam int XW = 34;
	localparam int ZW = 35;
	localparam int ITERS = 30;
	localparam int KW = 33;
	localparam int PW = 65;
	localparam int SW = 67;

	localparam logic signed [ZW-1:0] Q30_PI = 35'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_TWO_PI = 35'sd6746518852;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [KW-1:0] Q30_ONE = 33'sd1073741824;

	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_1 = 2'd1;
	localparam logic [1:0] AXIS_2 = 2'd2;
	localparam logic [1:0] AXIS_3 = 2'd3;

	typedef struct packed {
		logic signed [15:0] angle;
		logic [1:0] axis;
		logic kind;
		logic signed [31:0] comp_11;
		logic signed [31:0] comp_22;
		logic signed [31:0] comp_33;
		logic signed [31:0] comp_12;
		logic signed [31:0] comp_13;
		logic signed [31:0] comp_23;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_11;
		logic signed [31:0] out_22;
		logic signed [31:0] out_33;
		logic signed [31:0] out_12;
		logic signed [31:0] out_13;
		logic signed [31:0] out_23;
		logic axis_error;
	} result_t;

	// Carried alongside the angle while the CORDIC runs.
	typedef struct packed {
		logic [1:0] axis;
		logic kind;
		logic [5:0][31:0] comp;
	} pay_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic flip;
		pay_t pay;
	} cstate_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int idx);
		logic [31:0] v;
		begin
			case (idx)
				0: v = 32'h3243F6A8;
				1: v = 32'h1DAC6705;
				2: v = 32'h0FADBAFC;
				3: v = 32'h07F56EA6;
				4: v = 32'h03FEAB76;
				5: v = 32'h01FFD55B;
				6: v = 32'h00FFFAAA;
				7: v = 32'h007FFF55;
				8: v = 32'h003FFFEA;
				9: v = 32'h001FFFFD;
				10: v = 32'h000FFFFF;
				11: v = 32'h0007FFFF;
				12: v = 32'h0003FFFF;
				13: v = 32'h0001FFFF;
				14: v = 32'h0000FFFF;
				15: v = 32'h00007FFF;
				16: v = 32'h00003FFF;
				17: v = 32'h00001FFF;
				18: v = 32'h00000FFF;
				19: v = 32'h000007FF;
				20: v = 32'h000003FF;
				21: v = 32'h000001FF;
				22: v = 32'h000000FF;
				23: v = 32'h0000007F;
				24: v = 32'h0000003F;
				25: v = 32'h0000001F;
				26: v = 32'h0000000F;
				27: v = 32'h00000008;
				28: v = 32'h00000004;
				29: v = 32'h00000002;
				default: v = 32'h00000000;
			endcase
			return signed'({{(ZW-32){1'b0}}, v});
		end
	endfunction

endpackage
`default_nettype wire

### design/vvr_cordic_cell.sv
// One rotation-mode CORDIC step with its output register.
`default_nettype none
module vvr_cordic_cell #(
	parameter int Idx = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic valid_in,
	input wire vvr_pkg::cstate_t st_in,
	output logic valid_q,
	output vvr_pkg::cstate_t st_q
);

	logic signed [vvr_pkg::XW-1:0] xs;
	logic signed [vvr_pkg::XW-1:0] ys;
	vvr_pkg::cstate_t nxt;

	always_comb begin
		xs = st_in.x >>> Idx;
		ys = st_in.y >>> Idx;
		nxt = st_in;
		if (st_in.z >= 0) begin
			nxt.x = st_in.x - ys;
			nxt.y = st_in.y + xs;
			nxt.z = st_in.z - vvr_pkg::atan_q30(Idx);
		end else begin
			nxt.x = st_in.x + ys;
			nxt.y = st_in.y - xs;
			nxt.z = st_in.z + vvr_pkg::atan_q30(Idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

endmodule
`default_nettype wire

### design/vvr_mac_row.sv
// One matrix row: three products, then sum, rounding and saturation.
`default_nettype none
module vvr_mac_row (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [vvr_pkg::KW-1:0] k0,
	input wire logic signed [vvr_pkg::KW-1:0] k1,
	input wire logic signed [vvr_pkg::KW-1:0] k2,
	input wire logic signed [31:0] v0,
	input wire logic signed [31:0] v1,
	input wire logic signed [31:0] v2,
	output logic signed [31:0] res_q
);

	localparam int RW = vvr_pkg::SW - 30;

	logic signed [vvr_pkg::PW-1:0] p0_s1;
	logic signed [vvr_pkg::PW-1:0] p1_s1;
	logic signed [vvr_pkg::PW-1:0] p2_s1;
	logic signed [vvr_pkg::SW-1:0] acc;
	logic signed [vvr_pkg::SW-1:0] shifted;
	logic signed [RW-1:0] rounded;
	logic signed [31:0] sat;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= vvr_pkg::PW'(k0) * vvr_pkg::PW'(v0);
			p1_s1 <= vvr_pkg::PW'(k1) * vvr_pkg::PW'(v1);
			p2_s1 <= vvr_pkg::PW'(k2) * vvr_pkg::PW'(v2);
		end
	end

	always_comb begin
		acc = vvr_pkg::SW'(p0_s1) + vvr_pkg::SW'(p1_s1) + vvr_pkg::SW'(p2_s1)
			+ (vvr_pkg::SW'(1) <<< 29);
		shifted = acc >>> 30;
		rounded = shifted[RW-1:0];
		if (rounded > RW'(signed'(32'sh7FFFFFFF))) begin
			sat = 32'sh7FFFFFFF;
		end else if (rounded < RW'(signed'(32'sh80000000))) begin
			sat = 32'sh80000000;
		end else begin
			sat = rounded[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sat;
		end
	end

endmodule
`default_nettype wire

### design/voigt_vector_rotate_by_angle_unit.sv
// Top level of the Voigt vector rotation unit: angle reduction, CORDIC chain, matrix rows.
// Each accepted word rotates a six-component Voigt vector about axis 1, 2 or 3 by a Q4.12
// angle, as a stress or strain vector, and returns the saturated Q16.16 result; axis 0
// returns zeros with axis_error set. The unit takes one word per cycle unless a result
// waits under result_stall, and has 36 register stages: one angle reduction stage, a chain
// of 30 CORDIC cells, three coefficient stages and two multiply-accumulate stages. The
// whole pipeline holds while a result waits under result_stall.
`default_nettype none
module voigt_vector_rotate_by_angle_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_stall,
	input wire vvr_pkg::item_t item,
	output logic result_valid,
	input wire logic result_stall,
	output vvr_pkg::result_t result
);

	localparam int N = vvr_pkg::ITERS;
	localparam int XW = vvr_pkg::XW;
	localparam int ZW = vvr_pkg::ZW;
	localparam int KW = vvr_pkg::KW;

	logic en;
	assign en = !(result_valid && result_stall);
	assign item_stall = !en;

	// Angle reduction.
	logic signed [ZW-1:0] th0;
	logic signed [ZW-1:0] th1;
	logic signed [ZW-1:0] th2;
	logic flip;
	vvr_pkg::cstate_t st0;

	always_comb begin
		th0 = {{(ZW - 34){item.angle[15]}}, item.angle, 18'b0};
		if (th0 > vvr_pkg::Q30_PI) begin
			th1 = th0 - vvr_pkg::Q30_TWO_PI;
		end else if (th0 < -vvr_pkg::Q30_PI) begin
			th1 = th0 + vvr_pkg::Q30_TWO_PI;
		end else begin
			th1 = th0;
		end
		flip = 1'b0;
		if (th1 > vvr_pkg::Q30_HALF_PI) begin
			th2 = th1 - vvr_pkg::Q30_PI;
			flip = 1'b1;
		end else if (th1 < -vvr_pkg::Q30_HALF_PI) begin
			th2 = th1 + vvr_pkg::Q30_PI;
			flip = 1'b1;
		end else begin
			th2 = th1;
		end
		st0.x = vvr_pkg::CORDIC_GAIN;
		st0.y = '0;
		st0.z = th2;
		st0.flip = flip;
		st0.pay.axis = item.axis;
		st0.pay.kind = item.kind;
		st0.pay.comp[0] = item.comp_11;
		st0.pay.comp[1] = item.comp_22;
		st0.pay.comp[2] = item.comp_33;
		st0.pay.comp[3] = item.comp_12;
		st0.pay.comp[4] = item.comp_13;
		st0.pay.comp[5] = item.comp_23;
	end

	logic v_chain [0:N];
	vvr_pkg::cstate_t st_chain [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_chain[0] <= 1'b0;
		end else if (en) begin
			v_chain[0] <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_chain[0] <= st0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		vvr_cordic_cell #(
			.Idx(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.valid_in(v_chain[i]),
			.st_in(st_chain[i]),
			.valid_q(v_chain[i+1]),
			.st_q(st_chain[i+1])
		);
	end

	// Sign fix-up, then squares and cross product, then rounding.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0] c_s1, s_s1, c_s2, s_s2;
	logic signed [KW-1:0] c_s3, s_s3;
	vvr_pkg::pay_t pay_s1, pay_s2, pay_s3;
	logic signed [63:0] cc_s2, ss_s2, sc_s2;
	logic signed [KW-1:0] cc_s3, ss_s3, sc_s3, sc2_s3;
	logic signed [XW-1:0] cx, sx;
	logic signed [63:0] cc_r, ss_r, sc_r, sc2_r;
	logic err_s4, err_s5;

	always_comb begin
		cx = st_chain[N].flip ? -st_chain[N].x : st_chain[N].x;
		sx = st_chain[N].flip ? -st_chain[N].y : st_chain[N].y;
		cc_r = (cc_s2 + (64'sd1 <<< 29)) >>> 30;
		ss_r = (ss_s2 + (64'sd1 <<< 29)) >>> 30;
		sc_r = (sc_s2 + (64'sd1 <<< 29)) >>> 30;
		sc2_r = (sc_s2 + (64'sd1 <<< 28)) >>> 29;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_chain[N];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= cx[31:0];
			s_s1 <= sx[31:0];
			pay_s1 <= st_chain[N].pay;
			c_s2 <= c_s1;
			s_s2 <= s_s1;
			pay_s2 <= pay_s1;
			cc_s2 <= 64'(c_s1) * 64'(c_s1);
			ss_s2 <= 64'(s_s1) * 64'(s_s1);
			sc_s2 <= 64'(c_s1) * 64'(s_s1);
			c_s3 <= KW'(c_s2);
			s_s3 <= KW'(s_s2);
			pay_s3 <= pay_s2;
			cc_s3 <= cc_r[KW-1:0];
			ss_s3 <= ss_r[KW-1:0];
			sc_s3 <= sc_r[KW-1:0];
			sc2_s3 <= sc2_r[KW-1:0];
			err_s4 <= (pay_s3.axis == vvr_pkg::AXIS_NONE);
			err_s5 <= err_s4;
		end
	end

	// Row selection: each row has at most three nonzero coefficients.
	logic signed [KW-1:0] a, b, cmsq;
	logic signed [KW-1:0] k [6][3];
	logic [2:0] ci [6][3];
	logic signed [31:0] res [6];

	always_comb begin
		a = pay_s3.kind ? sc_s3 : sc2_s3;
		b = pay_s3.kind ? sc2_s3 : sc_s3;
		cmsq = cc_s3 - ss_s3;
		for (int r = 0; r < 6; r++) begin
			for (int j = 0; j < 3; j++) begin
				k[r][j] = '0;
				ci[r][j] = 3'd0;
			end
		end
		case (pay_s3.axis)
			vvr_pkg::AXIS_1: begin
				k[0][0] = vvr_pkg::Q30_ONE; ci[0][0] = 3'd0;
				k[1][0] = cc_s3; ci[1][0] = 3'd1;
				k[1][1] = ss_s3; ci[1][1] = 3'd2;
				k[1][2] = a; ci[1][2] = 3'd5;
				k[2][0] = ss_s3; ci[2][0] = 3'd1;
				k[2][1] = cc_s3; ci[2][1] = 3'd2;
				k[2][2] = -a; ci[2][2] = 3'd5;
				k[3][0] = c_s3; ci[3][0] = 3'd3;
				k[3][1] = s_s3; ci[3][1] = 3'd4;
				k[4][0] = -s_s3; ci[4][0] = 3'd3;
				k[4][1] = c_s3; ci[4][1] = 3'd4;
				k[5][0] = -b; ci[5][0] = 3'd1;
				k[5][1] = b; ci[5][1] = 3'd2;
				k[5][2] = cmsq; ci[5][2] = 3'd5;
			end
			vvr_pkg::AXIS_2: begin
				k[0][0] = cc_s3; ci[0][0] = 3'd0;
				k[0][1] = ss_s3; ci[0][1] = 3'd2;
				k[0][2] = -a; ci[0][2] = 3'd4;
				k[1][0] = vvr_pkg::Q30_ONE; ci[1][0] = 3'd1;
				k[2][0] = ss_s3; ci[2][0] = 3'd0;
				k[2][1] = cc_s3; ci[2][1] = 3'd2;
				k[2][2] = a; ci[2][2] = 3'd4;
				k[3][0] = c_s3; ci[3][0] = 3'd3;
				k[3][1] = -s_s3; ci[3][1] = 3'd5;
				k[4][0] = b; ci[4][0] = 3'd0;
				k[4][1] = -b; ci[4][1] = 3'd2;
				k[4][2] = cmsq; ci[4][2] = 3'd4;
				k[5][0] = s_s3; ci[5][0] = 3'd3;
				k[5][1] = c_s3; ci[5][1] = 3'd5;
			end
			vvr_pkg::AXIS_3: begin
				k[0][0] = cc_s3; ci[0][0] = 3'd0;
				k[0][1] = ss_s3; ci[0][1] = 3'd1;
				k[0][2] = a; ci[0][2] = 3'd3;
				k[1][0] = ss_s3; ci[1][0] = 3'd0;
				k[1][1] = cc_s3; ci[1][1] = 3'd1;
				k[1][2] = -a; ci[1][2] = 3'd3;
				k[2][0] = vvr_pkg::Q30_ONE; ci[2][0] = 3'd2;
				k[3][0] = -b; ci[3][0] = 3'd0;
				k[3][1] = b; ci[3][1] = 3'd1;
				k[3][2] = cmsq; ci[3][2] = 3'd3;
				k[4][0] = c_s3; ci[4][0] = 3'd4;
				k[4][1] = s_s3; ci[4][1] = 3'd5;
				k[5][0] = -s_s3; ci[5][0] = 3'd4;
				k[5][1] = c_s3; ci[5][1] = 3'd5;
			end
			default: begin
				// Invalid axis leaves every coefficient zero, so the rows come out zero.
			end
		endcase
	end

	for (genvar r = 0; r < 6; r++) begin : g_row
		vvr_mac_row u_row (
			.clk(clk),
			.en(en),
			.k0(k[r][0]),
			.k1(k[r][1]),
			.k2(k[r][2]),
			.v0(signed'(pay_s3.comp[ci[r][0]])),
			.v1(signed'(pay_s3.comp[ci[r][1]])),
			.v2(signed'(pay_s3.comp[ci[r][2]])),
			.res_q(res[r])
		);
	end

	assign result_valid = v_s5;
	assign result.out_11 = res[0];
	assign result.out_22 = res[1];
	assign result.out_33 = res[2];
	assign result.out_12 = res[3];
	assign result.out_13 = res[4];
	assign result.out_23 = res[5];
	assign result.axis_error = err_s5;

	// A flagged word carries an all-zero vector.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.axis_error |-> result.out_11 == 0 && result.out_22 == 0
		&& result.out_33 == 0 && result.out_12 == 0 && result.out_13 == 0
		&& result.out_23 == 0)
		else $error("axis error word with nonzero components");

	// After the quadrant fold the CORDIC x output is a positive cosine.
	a_cos_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_chain[N] |-> st_chain[N].x > 0)
		else $error("CORDIC x output not positive");

	// The pipeline holds only while the output word is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with no waiting result");

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the Voigt vector rotation unit.
`timescale 1ns / 1ps
module tb_top;

	localparam int LATENCY = 36;
	localparam int NUM_RANDOM = 600;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [15:0] ANG_PI = 16'sd12868; // pi in Q4.12, rounded
	localparam logic [15:0] ANG_HALF_PI = 16'sd6434;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	vvr_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	vvr_pkg::result_t result;

	vvr_pkg::result_t rotated_q[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	bit check_row = 1'b0;

	typedef struct {
		vvr_pkg::item_t in;
		bit known;
		vvr_pkg::result_t exp;
	} stim_row_t;
	stim_row_t stim_rows[$];

	voigt_vector_rotate_by_angle_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint round_q(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Computes the rotated Voigt vector for one word.
	function automatic vvr_pkg::result_t rotate_voigt(vvr_pkg::item_t w);
		vvr_pkg::result_t r;
		longint th, x, y, z, xs, ys, c, s, cc, ss, sc, sc2, cmsq, a, b, acc;
		longint m[6][6];
		longint v[6];
		bit flip;
		r = '0;
		if (w.axis == vvr_pkg::AXIS_NONE) begin
			r.axis_error = 1'b1;
			return r;
		end
		v[0] = longint'(w.comp_11); v[1] = longint'(w.comp_22); v[2] = longint'(w.comp_33);
		v[3] = longint'(w.comp_12); v[4] = longint'(w.comp_13); v[5] = longint'(w.comp_23);
		th = longint'(w.angle) * 262144;
		flip = 1'b0;
		if (th > longint'(vvr_pkg::Q30_PI)) th -= longint'(vvr_pkg::Q30_TWO_PI);
		else if (th < -longint'(vvr_pkg::Q30_PI)) th += longint'(vvr_pkg::Q30_TWO_PI);
		if (th > longint'(vvr_pkg::Q30_HALF_PI)) begin
			th -= longint'(vvr_pkg::Q30_PI); flip = 1'b1;
		end else if (th < -longint'(vvr_pkg::Q30_HALF_PI)) begin
			th += longint'(vvr_pkg::Q30_PI); flip = 1'b1;
		end
		x = longint'(vvr_pkg::CORDIC_GAIN); y = 0; z = th;
		for (int i = 0; i < vvr_pkg::ITERS; i++) begin
			xs = shr_floor(x, i); ys = shr_floor(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(vvr_pkg::atan_q30(i));
			end else begin
				x += ys; y -= xs; z += longint'(vvr_pkg::atan_q30(i));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		cc = round_q(c * c, 30); ss = round_q(s * s, 30);
		sc = round_q(c * s, 30); sc2 = round_q(c * s, 29);
		cmsq = cc - ss;
		a = w.kind ? sc : sc2;
		b = w.kind ? sc2 : sc;
		foreach (m[i, j]) m[i][j] = 0;
		case (w.axis)
			vvr_pkg::AXIS_1: begin
				m[0][0] = longint'(vvr_pkg::Q30_ONE);
				m[1][1] = cc; m[1][2] = ss; m[1][5] = a;
				m[2][1] = ss; m[2][2] = cc; m[2][5] = -a;
				m[3][3] = c; m[3][4] = s;
				m[4][3] = -s; m[4][4] = c;
				m[5][1] = -b; m[5][2] = b; m[5][5] = cmsq;
			end
			vvr_pkg::AXIS_2: begin
				m[0][0] = cc; m[0][2] = ss; m[0][4] = -a;
				m[1][1] = longint'(vvr_pkg::Q30_ONE);
				m[2][0] = ss; m[2][2] = cc; m[2][4] = a;
				m[3][3] = c; m[3][5] = -s;
				m[4][0] = b; m[4][2] = -b; m[4][4] = cmsq;
				m[5][3] = s; m[5][5] = c;
			end
			default: begin
				m[0][0] = cc; m[0][1] = ss; m[0][3] = a;
				m[1][0] = ss; m[1][1] = cc; m[1][3] = -a;
				m[2][2] = longint'(vvr_pkg::Q30_ONE);
				m[3][0] = -b; m[3][1] = b; m[3][3] = cmsq;
				m[4][4] = c; m[4][5] = s;
				m[5][4] = -s; m[5][5] = c;
			end
		endcase
		for (int i = 0; i < 6; i++) begin
			acc = 0;
			for (int j = 0; j < 6; j++) acc += m[i][j] * v[j];
			v[i] = v[i]; // rows read the original vector below
			case (i)
				0: r.out_11 = clamp32(round_q(acc, 30));
				1: r.out_22 = clamp32(round_q(acc, 30));
				2: r.out_33 = clamp32(round_q(acc, 30));
				3: r.out_12 = clamp32(round_q(acc, 30));
				4: r.out_13 = clamp32(round_q(acc, 30));
				default: r.out_23 = clamp32(round_q(acc, 30));
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("Mismatch on word %0d, %s: got %h, expected %h", words_checked, field, got, want);
	endtask

	// Result side: stall at random, or for a long stretch when hold_off is set.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (rotated_q.size() == 0) begin
					report_mismatch("unexpected word", 32'h0, 32'h0);
				end else begin
					vvr_pkg::result_t e;
					e = rotated_q.pop_front();
					if (result.out_11 !== e.out_11) report_mismatch("out_11", result.out_11, e.out_11);
					if (result.out_22 !== e.out_22) report_mismatch("out_22", result.out_22, e.out_22);
					if (result.out_33 !== e.out_33) report_mismatch("out_33", result.out_33, e.out_33);
					if (result.out_12 !== e.out_12) report_mismatch("out_12", result.out_12, e.out_12);
					if (result.out_13 !== e.out_13) report_mismatch("out_13", result.out_13, e.out_13);
					if (result.out_23 !== e.out_23) report_mismatch("out_23", result.out_23, e.out_23);
					if (result.axis_error !== e.axis_error)
						report_mismatch("axis_error", 32'(result.axis_error), 32'(e.axis_error));
				end
				words_checked++;
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Offers one word and waits until the unit takes it; valid stays high for the next word.
	task automatic send_word(vvr_pkg::item_t w, bit known, vvr_pkg::result_t want);
		vvr_pkg::result_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		p = rotate_voigt(w);
		if (known && p !== want) begin
			errors++;
			$display("Table entry disagrees with prediction on word %0d", words_sent);
		end
		rotated_q.push_back(p);
		@(posedge clk);
		while (item_stall) @(posedge clk);
		words_sent++;
	endtask

	function automatic vvr_pkg::item_t random_word();
		vvr_pkg::item_t w;
		w.angle = 16'($urandom);
		w.axis = ($urandom_range(9) == 0) ? vvr_pkg::AXIS_NONE : 2'($urandom_range(3, 1));
		w.kind = 1'($urandom);
		case ($urandom_range(3))
			0: begin
				// Extreme magnitudes to reach saturation.
				w.comp_11 = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
				w.comp_22 = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
				w.comp_33 = $urandom; w.comp_12 = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
				w.comp_13 = $urandom; w.comp_23 = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			end
			1: begin
				w.comp_11 = $signed(17'($urandom)) <<< 8; w.comp_22 = $signed(17'($urandom)) <<< 8;
				w.comp_33 = $signed(17'($urandom)) <<< 8; w.comp_12 = $signed(17'($urandom)) <<< 8;
				w.comp_13 = $signed(17'($urandom)) <<< 8; w.comp_23 = $signed(17'($urandom)) <<< 8;
			end
			default: begin
				w.comp_11 = $urandom; w.comp_22 = $urandom; w.comp_33 = $urandom;
				w.comp_12 = $urandom; w.comp_13 = $urandom; w.comp_23 = $urandom;
			end
		endcase
		return w;
	endfunction

	function automatic vvr_pkg::item_t make_word(logic [15:0] ang, logic [1:0] ax, logic k,
			logic [31:0] v);
		vvr_pkg::item_t w;
		w.angle = ang; w.axis = ax; w.kind = k;
		w.comp_11 = v; w.comp_22 = -v; w.comp_33 = v >>> 1;
		w.comp_12 = v >>> 2; w.comp_13 = -(v >>> 3); w.comp_23 = v >>> 4;
		return w;
	endfunction

	task automatic add_row(vvr_pkg::item_t w, bit known, vvr_pkg::result_t want);
		stim_row_t row;
		row.in = w; row.known = known; row.exp = want;
		stim_rows.push_back(row);
	endtask

	// Drops valid and waits until every expected result has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (rotated_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		vvr_pkg::result_t zero_err;
		vvr_pkg::result_t none;
		vvr_pkg::item_t w;
		zero_err = '0; zero_err.axis_error = 1'b1;
		none = '0;
		// Invalid axis gives zeros and the error flag, whatever else is set.
		w = '1; w.axis = vvr_pkg::AXIS_NONE; add_row(w, 1'b1, zero_err);
		w = '0; w.axis = vvr_pkg::AXIS_NONE; add_row(w, 1'b1, zero_err);
		// Zero vector rotates to zero.
		w = '0; w.axis = vvr_pkg::AXIS_1; w.angle = 16'sd1000; add_row(w, 1'b1, none);
		for (int ax = 1; ax <= 3; ax++) begin
			for (int k = 0; k < 2; k++) begin
				add_row(make_word(16'sd0, 2'(ax), 1'(k), 32'sh00010000), check_row, none);
				add_row(make_word(ANG_HALF_PI, 2'(ax), 1'(k), 32'sh00230000), check_row, none);
			end
			add_row(make_word(ANG_PI, 2'(ax), 1'b0, 32'sh00050000), check_row, none);
			add_row(make_word(-ANG_PI, 2'(ax), 1'b1, 32'sh00050000), check_row, none);
		end
		add_row(make_word(16'sh7FFF, vvr_pkg::AXIS_2, 1'b0, 32'sh7FFFFFFF), check_row, none);
		add_row(make_word(16'sh8000, vvr_pkg::AXIS_3, 1'b1, 32'sh80000000), check_row, none);
		add_row(make_word(16'sd3217, vvr_pkg::AXIS_1, 1'b1, 32'sh7FFFFFFF), check_row, none);
		add_row(make_word(-16'sd3217, vvr_pkg::AXIS_3, 1'b0, 32'sh80000000), check_row, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) send_word(stim_rows[i].in, stim_rows[i].known, stim_rows[i].exp);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 75; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 75; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			if (ph == 0) hold_off = 120; // the pipeline fills and stalls its input
			for (int n = 0; n < NUM_RANDOM / 4; n++) send_word(random_word(), 1'b0, none);
			if (ph == 1) drain(); // sender waits for every result
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d words (directed table, all axes and kinds, saturation, pi cases)",
			words_sent);
		$display("Checked %0d results under four idle and stall mixes", words_checked);
		if (errors == 0 && rotated_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
